FILE: hw/rtl/rwst_pkg.sv
// shared types, field widths and codes of the random walk spanning tree carver
package rwst_pkg;

  // default grid size
  localparam int unsigned GRID_COLS_DEF = 32;
  localparam int unsigned GRID_ROWS_DEF = 16;

  // request and result field widths
  localparam int unsigned COL_W = 5;
  localparam int unsigned ROW_W = 4;
  localparam int unsigned CNT_W = 10;

  // operation codes
  localparam logic OP_BEGIN = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // direction codes
  localparam logic [1:0] DIR_LEFT  = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_UP    = 2'd2;
  localparam logic [1:0] DIR_DOWN  = 2'd3;

  // opened wall codes
  localparam logic SIDE_LEFT = 1'b0;
  localparam logic SIDE_TOP  = 1'b1;

  // input request payload
  typedef struct packed {
    logic             operation;
    logic [1:0]       direction;
    logic [COL_W-1:0] start_col;
    logic [ROW_W-1:0] start_row;
  } in_t;

  // result payload
  typedef struct packed {
    logic             moved;
    logic             carved;
    logic [COL_W-1:0] wall_col;
    logic [ROW_W-1:0] wall_row;
    logic             wall_side;
    logic [COL_W-1:0] walker_col;
    logic [ROW_W-1:0] walker_row;
    logic [CNT_W-1:0] cells_left;
    logic             done_res;
  } out_t;

  // update command from the walker to the visited map
  typedef struct packed {
    logic start;
    logic step;
    logic carve;
    logic up;
    logic down;
  } map_cmd_t;

endpackage

FILE: hw/rtl/rwst_in_if.sv
// request channel of the carver
interface rwst_in_if;
  logic           valid;
  logic           ready;
  rwst_pkg::in_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/rwst_out_if.sv
// result channel of the carver
interface rwst_out_if;
  logic           valid;
  logic           ready;
  rwst_pkg::out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/rwst_ram.sv
// generic ram, one write port and two registered read ports
module rwst_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_a_q;
  logic [Width-1:0] rdata_b_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered reads
  always_ff @(posedge clk_i) begin
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

FILE: hw/rtl/rwst_vmap.sv
// visited map: row memory with row valid bits and a three row window around the walker
module rwst_vmap #(
  parameter int unsigned GridCols = rwst_pkg::GRID_COLS_DEF,
  parameter int unsigned GridRows = rwst_pkg::GRID_ROWS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rwst_pkg::map_cmd_t          cmd_i,
  input  logic [$clog2(GridCols)-1:0] col_i,
  input  logic [$clog2(GridRows)-1:0] row_i,
  output logic [GridCols-1:0]         above_o,
  output logic [GridCols-1:0]         cur_o,
  output logic [GridCols-1:0]         below_o
);

  localparam int unsigned RW = $clog2(GridRows);

  logic [GridCols-1:0] above_q, above_d;
  logic [GridCols-1:0] cur_q, cur_d;
  logic [GridCols-1:0] below_q, below_d;
  logic [GridRows-1:0] row_vld_q, row_vld_d;
  logic                rd_a_ok_q, rd_a_ok_d;
  logic                rd_b_ok_q, rd_b_ok_d;
  logic [GridCols-1:0] col_bit;
  logic [RW:0]         up_ext;
  logic [RW:0]         dn_ext;
  logic                up_ok;
  logic                dn_ok;
  logic [RW-1:0]       rd_a_addr;
  logic [RW-1:0]       rd_b_addr;
  logic [GridCols-1:0] rd_a_data;
  logic [GridCols-1:0] rd_b_data;
  logic                mem_we;

  // window reset on begin, window shift and carve update
  always_comb begin
    col_bit   = {{(GridCols-1){1'b0}}, 1'b1} << col_i;
    above_d   = above_q;
    cur_d     = cur_q;
    below_d   = below_q;
    row_vld_d = row_vld_q;
    if (cmd_i.start) begin
      above_d          = '0;
      cur_d            = col_bit;
      below_d          = '0;
      row_vld_d        = '0;
      row_vld_d[row_i] = 1'b1;
    end else if (cmd_i.step) begin
      if (cmd_i.up) begin
        below_d = cur_q;
        cur_d   = above_q;
        above_d = rd_a_ok_q ? rd_a_data : '0;
      end else if (cmd_i.down) begin
        above_d = cur_q;
        cur_d   = below_q;
        below_d = rd_b_ok_q ? rd_b_data : '0;
      end
      if (cmd_i.carve) begin
        cur_d            = cur_d | col_bit;
        row_vld_d[row_i] = 1'b1;
      end
    end
  end

  assign mem_we = cmd_i.start | (cmd_i.step & cmd_i.carve);

  // prefetch of the rows two above and two below the next walker row
  always_comb begin
    up_ext    = {1'b0, row_i} - (RW+1)'(2);
    dn_ext    = {1'b0, row_i} + (RW+1)'(2);
    up_ok     = {1'b0, row_i} >= (RW+1)'(2);
    dn_ok     = dn_ext < (RW+1)'(GridRows);
    rd_a_addr = up_ok ? up_ext[RW-1:0] : '0;
    rd_b_addr = dn_ok ? dn_ext[RW-1:0] : '0;
    rd_a_ok_d = up_ok & row_vld_d[rd_a_addr];
    rd_b_ok_d = dn_ok & row_vld_d[rd_b_addr];
  end

  rwst_ram #(
    .Width (GridCols),
    .Depth (GridRows)
  ) u_row_ram (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (row_i),
    .wdata_i   (cur_d),
    .raddr_a_i (rd_a_addr),
    .raddr_b_i (rd_b_addr),
    .rdata_a_o (rd_a_data),
    .rdata_b_o (rd_b_data)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_a_ok_q <= 1'b0;
      rd_b_ok_q <= 1'b0;
    end else begin
      row_vld_q <= row_vld_d;
      rd_a_ok_q <= rd_a_ok_d;
      rd_b_ok_q <= rd_b_ok_d;
    end
  end

  // window rows
  always_ff @(posedge clk_i) begin
    above_q <= above_d;
    cur_q   <= cur_d;
    below_q <= below_d;
  end

  assign above_o = above_q;
  assign cur_o   = cur_q;
  assign below_o = below_q;

endmodule

FILE: hw/rtl/random_walk_spanning_tree_carver_core.sv
// path: an accepted request is registered in the request stage, its result in the result register
// throughput: one request per cycle while results are taken, set by the walker and visited-row
// window update for each request; a stalled result blocks new requests once the request stage is full
// reset: walker at column 0 row 0, unvisited count 0 so steps are ignored until a begin
// request; visited rows read as empty through row valid bits, no clearing pass
// top level of the random walk spanning tree carver
module random_walk_spanning_tree_carver_core #(
  parameter int unsigned GridCols = rwst_pkg::GRID_COLS_DEF,
  parameter int unsigned GridRows = rwst_pkg::GRID_ROWS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  rwst_in_if.sink          in_i,
  rwst_out_if.source       out_o
);

  localparam int unsigned CW    = $clog2(GridCols);
  localparam int unsigned RW    = $clog2(GridRows);
  localparam int unsigned Cells = GridCols * GridRows;
  localparam int unsigned NW    = $clog2(Cells + 1);
  localparam int unsigned OutColW = rwst_pkg::COL_W;
  localparam int unsigned OutRowW = rwst_pkg::ROW_W;
  localparam int unsigned OutCntW = rwst_pkg::CNT_W;

  logic                s1_vld_q;
  rwst_pkg::in_t       s1_q;
  logic                res_vld_q;
  rwst_pkg::out_t      res_q, res_d;
  logic [CW-1:0]       col_q, col_d, col_n;
  logic [RW-1:0]       row_q, row_d, row_n;
  logic [NW-1:0]       cnt_q, cnt_d, cnt_n;
  logic                adv;
  logic                is_begin;
  logic                walk_done;
  logic                ok;
  logic                hit;
  logic                moved;
  logic                carve;
  logic [CW-1:0]       nc;
  logic [RW-1:0]       nr;
  logic [CW-1:0]       look_col;
  logic [CW-1:0]       start_col;
  logic [RW-1:0]       start_row;
  logic [CW-1:0]       wall_col;
  logic [RW-1:0]       wall_row;
  rwst_pkg::map_cmd_t  map_cmd;
  logic [GridCols-1:0] above_bits;
  logic [GridCols-1:0] cur_bits;
  logic [GridCols-1:0] below_bits;

  // handshake: the request stage moves on whenever the result register is empty or its result is taken
  assign adv        = s1_vld_q & (~res_vld_q | out_o.ready);
  assign in_i.ready = ~s1_vld_q | adv;

  // begin: saturate the start cell into the grid
  always_comb begin
    start_col = (32'(s1_q.start_col) >= 32'(GridCols)) ? CW'(GridCols - 1) : CW'(s1_q.start_col);
    start_row = (32'(s1_q.start_row) >= 32'(GridRows)) ? RW'(GridRows - 1) : RW'(s1_q.start_row);
  end

  // step: bounds check and neighbor position
  always_comb begin
    nc = col_q;
    nr = row_q;
    ok = 1'b0;
    case (s1_q.direction)
      rwst_pkg::DIR_LEFT: begin
        ok = col_q != '0;
        nc = col_q - CW'(1);
      end
      rwst_pkg::DIR_RIGHT: begin
        ok = (32'(col_q) + 32'd1) < 32'(GridCols);
        nc = col_q + CW'(1);
      end
      rwst_pkg::DIR_UP: begin
        ok = row_q != '0;
        nr = row_q - RW'(1);
      end
      rwst_pkg::DIR_DOWN: begin
        ok = (32'(row_q) + 32'd1) < 32'(GridRows);
        nr = row_q + RW'(1);
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  // visited lookup in the window
  always_comb begin
    look_col = ok ? nc : col_q;
    case (s1_q.direction)
      rwst_pkg::DIR_UP:   hit = above_bits[look_col];
      rwst_pkg::DIR_DOWN: hit = below_bits[look_col];
      default:            hit = cur_bits[look_col];
    endcase
  end

  assign is_begin  = s1_q.operation == rwst_pkg::OP_BEGIN;
  assign walk_done = cnt_q == '0;
  assign moved     = ~is_begin & ~walk_done & ok;
  assign carve     = moved & ~hit;

  // new walker position and count for this request
  always_comb begin
    col_n = col_q;
    row_n = row_q;
    cnt_n = cnt_q;
    if (is_begin) begin
      col_n = start_col;
      row_n = start_row;
      cnt_n = NW'(Cells - 1);
    end else if (moved) begin
      col_n = nc;
      row_n = nr;
      if (carve) begin
        cnt_n = cnt_q - NW'(1);
      end
    end
  end

  assign col_d = adv ? col_n : col_q;
  assign row_d = adv ? row_n : row_q;
  assign cnt_d = adv ? cnt_n : cnt_q;

  // wall of the cell with the larger coordinate
  assign wall_col = (s1_q.direction == rwst_pkg::DIR_RIGHT) ? nc : col_q;
  assign wall_row = (s1_q.direction == rwst_pkg::DIR_DOWN) ? nr : row_q;

  // result assembly
  always_comb begin
    res_d            = '0;
    res_d.moved      = moved;
    res_d.carved     = carve;
    if (carve) begin
      res_d.wall_col  = OutColW'(wall_col);
      res_d.wall_row  = OutRowW'(wall_row);
      res_d.wall_side = s1_q.direction[1] ? rwst_pkg::SIDE_TOP : rwst_pkg::SIDE_LEFT;
    end
    res_d.walker_col = OutColW'(col_n);
    res_d.walker_row = OutRowW'(row_n);
    res_d.cells_left = OutCntW'(cnt_n);
    res_d.done_res   = cnt_n == '0;
  end

  // map update command
  always_comb begin
    map_cmd       = '0;
    map_cmd.start = adv & is_begin;
    map_cmd.step  = adv & moved;
    map_cmd.carve = adv & carve;
    map_cmd.up    = s1_q.direction == rwst_pkg::DIR_UP;
    map_cmd.down  = s1_q.direction == rwst_pkg::DIR_DOWN;
  end

  rwst_vmap #(
    .GridCols (GridCols),
    .GridRows (GridRows)
  ) u_vmap (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (map_cmd),
    .col_i   (col_d),
    .row_i   (row_d),
    .above_o (above_bits),
    .cur_o   (cur_bits),
    .below_o (below_bits)
  );

  // control state and valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
      col_q     <= '0;
      row_q     <= '0;
      cnt_q     <= '0;
    end else begin
      if (in_i.ready) begin
        s1_vld_q <= in_i.valid;
      end
      if (adv) begin
        res_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        res_vld_q <= 1'b0;
      end
      col_q <= col_d;
      row_q <= row_d;
      cnt_q <= cnt_d;
    end
  end

  // request and result payload registers
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_q <= in_i.payload;
    end
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid   = res_vld_q;
  assign out_o.payload = res_q;

  // walker stays inside the grid
  a_walker_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(col_q) < 32'(GridCols)) && (32'(row_q) < 32'(GridRows)))
    else $error("walker left the grid");

  // unvisited count never exceeds the cells other than the start
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) < Cells)
    else $error("unvisited count out of range");

  // a carve takes exactly one cell off the count
  a_carve_decrements: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && carve) |=> (cnt_q == $past(cnt_q) - NW'(1)))
    else $error("carve did not decrement the count");

  // a carved wall always comes with a move
  a_carve_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_q && res_q.carved) |-> res_q.moved)
    else $error("carved without a move");

  // a step with the walk done leaves the walker in place
  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && !is_begin && walk_done) |=> (col_q == $past(col_q) && row_q == $past(row_q)))
    else $error("walker moved after the walk was done");

endmodule

FILE: tb/sv/rwst_walk_check_pkg.sv
// result predictor and scoreboard for the random walk spanning tree carver testbench
`timescale 1ns / 100ps
package rwst_walk_check_pkg;

  localparam int unsigned GRID_COLS = rwst_pkg::GRID_COLS_DEF;
  localparam int unsigned GRID_ROWS = rwst_pkg::GRID_ROWS_DEF;
  localparam int unsigned COL_W     = rwst_pkg::COL_W;
  localparam int unsigned ROW_W     = rwst_pkg::ROW_W;
  localparam int unsigned CNT_W     = rwst_pkg::CNT_W;

  class rwst_walk_scoreboard;
    // mirror of the walker state
    bit               visited_cells [GRID_ROWS][GRID_COLS];
    bit [COL_W-1:0]   walker_col;
    bit [ROW_W-1:0]   walker_row;
    int unsigned      cells_unvisited;
    rwst_pkg::out_t   pending_results [$];
    int unsigned      mismatches;

    function new();
      clear_map();
      walker_col      = '0;
      walker_row      = '0;
      cells_unvisited = 0;
      mismatches      = 0;
    endfunction

    function void clear_map();
      foreach (visited_cells[r, c]) visited_cells[r][c] = 1'b0;
    endfunction

    // work out the result of one accepted request and queue it
    function void note_request(rwst_pkg::in_t req);
      rwst_pkg::out_t res;
      int unsigned    nc;
      int unsigned    nr;
      bit             in_grid;
      res = '0;
      if (req.operation == rwst_pkg::OP_BEGIN) begin
        nc = 32'(req.start_col);
        nr = 32'(req.start_row);
        // start beyond the grid saturates to the last cell
        if (nc >= GRID_COLS) nc = GRID_COLS - 1;
        if (nr >= GRID_ROWS) nr = GRID_ROWS - 1;
        clear_map();
        walker_col = COL_W'(nc);
        walker_row = ROW_W'(nr);
        visited_cells[nr][nc] = 1'b1;
        cells_unvisited = GRID_COLS * GRID_ROWS - 1;
      end else if (cells_unvisited != 0) begin
        nc = 32'(walker_col);
        nr = 32'(walker_row);
        in_grid = 1'b1;
        case (req.direction)
          rwst_pkg::DIR_LEFT: begin
            if (nc == 0) in_grid = 1'b0; else nc = nc - 1;
          end
          rwst_pkg::DIR_RIGHT: begin
            if (nc + 1 >= GRID_COLS) in_grid = 1'b0; else nc = nc + 1;
          end
          rwst_pkg::DIR_UP: begin
            if (nr == 0) in_grid = 1'b0; else nr = nr - 1;
          end
          default: begin
            if (nr + 1 >= GRID_ROWS) in_grid = 1'b0; else nr = nr + 1;
          end
        endcase
        if (in_grid) begin
          res.moved = 1'b1;
          if (!visited_cells[nr][nc]) begin
            visited_cells[nr][nc] = 1'b1;
            cells_unvisited = cells_unvisited - 1;
            res.carved = 1'b1;
            // the opened wall belongs to the cell further right or down
            res.wall_col  = COL_W'((nc > 32'(walker_col)) ? nc : 32'(walker_col));
            res.wall_row  = ROW_W'((nr > 32'(walker_row)) ? nr : 32'(walker_row));
            res.wall_side = (req.direction == rwst_pkg::DIR_UP ||
                             req.direction == rwst_pkg::DIR_DOWN) ?
                            rwst_pkg::SIDE_TOP : rwst_pkg::SIDE_LEFT;
          end
          walker_col = COL_W'(nc);
          walker_row = ROW_W'(nr);
        end
      end
      res.walker_col = walker_col;
      res.walker_row = walker_row;
      res.cells_left = CNT_W'(cells_unvisited);
      res.done_res   = (cells_unvisited == 0);
      pending_results.push_back(res);
    endfunction

    function void check_field(string field_name, logic [CNT_W-1:0] exp_val,
                              logic [CNT_W-1:0] act_val);
      if (act_val !== exp_val) begin
        $error("%s expected %0d got %0d", field_name, exp_val, act_val);
        mismatches++;
      end
    endfunction

    // compare one result with the oldest prediction
    function void check_result(rwst_pkg::out_t got);
      rwst_pkg::out_t exp_res;
      if (pending_results.size() == 0) begin
        $error("result with no request pending");
        mismatches++;
        return;
      end
      exp_res = pending_results.pop_front();
      check_field("moved", CNT_W'(exp_res.moved), CNT_W'(got.moved));
      check_field("carved", CNT_W'(exp_res.carved), CNT_W'(got.carved));
      check_field("wall_col", CNT_W'(exp_res.wall_col), CNT_W'(got.wall_col));
      check_field("wall_row", CNT_W'(exp_res.wall_row), CNT_W'(got.wall_row));
      check_field("wall_side", CNT_W'(exp_res.wall_side), CNT_W'(got.wall_side));
      check_field("walker_col", CNT_W'(exp_res.walker_col), CNT_W'(got.walker_col));
      check_field("walker_row", CNT_W'(exp_res.walker_row), CNT_W'(got.walker_row));
      check_field("cells_left", exp_res.cells_left, got.cells_left);
      check_field("done_res", CNT_W'(exp_res.done_res), CNT_W'(got.done_res));
    endfunction
  endclass

endpackage

FILE: tb/sv/random_walk_spanning_tree_carver_core_tb.sv
// testbench top of the random walk spanning tree carver core
`timescale 1ns / 100ps
module random_walk_spanning_tree_carver_core_tb;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned COL_W       = rwst_pkg::COL_W;
  localparam int unsigned ROW_W       = rwst_pkg::ROW_W;
  localparam int unsigned GRID_COLS   = rwst_walk_check_pkg::GRID_COLS;
  localparam int unsigned GRID_ROWS   = rwst_walk_check_pkg::GRID_ROWS;

  logic clk_i = 1'b0;
  logic rst_ni;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned cycle_count   = 0;

  rwst_walk_check_pkg::rwst_walk_scoreboard sb = new();

  rwst_in_if  in_if ();
  rwst_out_if out_if ();

  random_walk_spanning_tree_carver_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #5 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // result side stalls
  always @(posedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // check every accepted result
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) sb.check_result(out_if.payload);
  end

  // present one request, with random idle cycles ahead of it, until accepted
  task automatic send_request(rwst_pkg::in_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= req;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_request(req);
  endtask

  task automatic send_begin(logic [COL_W-1:0] col, logic [ROW_W-1:0] row);
    rwst_pkg::in_t req;
    req.operation = rwst_pkg::OP_BEGIN;
    req.direction = 2'($urandom_range(3));
    req.start_col = col;
    req.start_row = row;
    send_request(req);
  endtask

  task automatic send_step(logic [1:0] dir);
    rwst_pkg::in_t req;
    req.operation = rwst_pkg::OP_STEP;
    req.direction = dir;
    req.start_col = COL_W'($urandom_range(31));
    req.start_row = ROW_W'($urandom_range(15));
    send_request(req);
  endtask

  // steer toward unvisited cells so the walk gets deep, with some random wandering
  function automatic logic [1:0] pick_direction(int unsigned wander_pct);
    int          c;
    int          r;
    int          reach;
    int          best_dist;
    int          tc;
    int          tr;
    logic [1:0]  opts [$];
    if ($urandom_range(99) < wander_pct) return 2'($urandom_range(3));
    c = int'(sb.walker_col);
    r = int'(sb.walker_row);
    if (c > 0 && !sb.visited_cells[r][c-1]) opts.push_back(rwst_pkg::DIR_LEFT);
    if (c < int'(GRID_COLS) - 1 && !sb.visited_cells[r][c+1])
      opts.push_back(rwst_pkg::DIR_RIGHT);
    if (r > 0 && !sb.visited_cells[r-1][c]) opts.push_back(rwst_pkg::DIR_UP);
    if (r < int'(GRID_ROWS) - 1 && !sb.visited_cells[r+1][c])
      opts.push_back(rwst_pkg::DIR_DOWN);
    if (opts.size() != 0) return opts[$urandom_range(opts.size() - 1)];
    // head for the nearest unvisited cell
    best_dist = int'(GRID_COLS + GRID_ROWS);
    tc = c;
    tr = r;
    for (int rr = 0; rr < int'(GRID_ROWS); rr++) begin
      for (int cc = 0; cc < int'(GRID_COLS); cc++) begin
        if (!sb.visited_cells[rr][cc]) begin
          reach = ((cc > c) ? cc - c : c - cc) + ((rr > r) ? rr - r : r - rr);
          if (reach < best_dist) begin
            best_dist = reach;
            tc = cc;
            tr = rr;
          end
        end
      end
    end
    if (tc < c) return rwst_pkg::DIR_LEFT;
    if (tc > c) return rwst_pkg::DIR_RIGHT;
    if (tr < r) return rwst_pkg::DIR_UP;
    return rwst_pkg::DIR_DOWN;
  endfunction

  // random walks, optionally one walk carried through to completion
  task automatic run_walk_phase(int unsigned item_budget, bit full_walk);
    int unsigned sent;
    int unsigned walk_len;
    sent = 0;
    if (full_walk) begin
      send_begin(COL_W'($urandom_range(31)), ROW_W'($urandom_range(15)));
      sent++;
      while (sb.cells_unvisited != 0) begin
        send_step(pick_direction(4));
        sent++;
      end
      // steps once done are ignored
      repeat ($urandom_range(3, 6)) send_step(2'($urandom_range(3)));
    end
    while (sent < item_budget) begin
      send_begin(COL_W'($urandom_range(31)), ROW_W'($urandom_range(15)));
      sent++;
      walk_len = $urandom_range(10, 100);
      for (int k = 0; k < walk_len && sb.cells_unvisited != 0; k++) begin
        // occasional restart in the middle of a walk
        if ($urandom_range(99) < 4) begin
          send_begin(COL_W'($urandom_range(31)), ROW_W'($urandom_range(15)));
        end else begin
          send_step(pick_direction(20));
        end
        sent++;
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_if.valid   = 1'b0;
    in_if.payload = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: step while done after reset, corners, rejections, carves, revisits
    send_step(rwst_pkg::DIR_RIGHT);
    send_begin(5'd0, 4'd0);
    send_step(rwst_pkg::DIR_LEFT);
    send_step(rwst_pkg::DIR_UP);
    send_step(rwst_pkg::DIR_RIGHT);
    send_step(rwst_pkg::DIR_DOWN);
    send_step(rwst_pkg::DIR_LEFT);
    send_step(rwst_pkg::DIR_UP);
    send_begin(5'd31, 4'd15);
    send_step(rwst_pkg::DIR_RIGHT);
    send_step(rwst_pkg::DIR_DOWN);
    send_step(rwst_pkg::DIR_UP);
    send_step(rwst_pkg::DIR_LEFT);
    send_step(rwst_pkg::DIR_DOWN);
    send_begin(5'd17, 4'd9);
    send_step(rwst_pkg::DIR_UP);
    send_step(rwst_pkg::DIR_DOWN);
    send_step(rwst_pkg::DIR_RIGHT);
    send_step(rwst_pkg::DIR_LEFT);
    send_begin(5'd31, 4'd0);
    send_step(rwst_pkg::DIR_UP);
    send_begin(5'd0, 4'd15);
    send_step(rwst_pkg::DIR_LEFT);

    // random: sender idles lightly, receiver heavily
    send_idle_pct = 6;
    recv_idle_pct = 55;
    run_walk_phase(250, 1'b1);
    // the other way round
    send_idle_pct = 55;
    recv_idle_pct = 6;
    run_walk_phase(150, 1'b0);
    // no idling
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_walk_phase(150, 1'b0);

    in_if.valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
